### rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// shared types and constants of the byte signature find and replace block
// ----------------------------------------------------------------------------
package bsfr_pkg;

   // bytes the delay line can hold before the oldest one leaves
   localparam int HISTORY_DEPTH = 7;
   // bytes overwritten from the match start
   localparam int PATCH_BYTES = 8;
   // default compare lanes
   localparam int MAX_SIGNATURE_BYTES_DEFAULT = 8;
   // entries between front and back end
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      CSR_SIGNATURE   = 2'd0,
      CSR_SIG_LENGTH  = 2'd1,
      CSR_REPL_VALUE  = 2'd2,
      CSR_REPL_ENABLE = 2'd3
   } csr_index_type;

   // one unit of output work: up to eight bytes to be emitted in order
   typedef struct packed {
      logic [8*PATCH_BYTES-1:0] bytes;
      logic [3:0]               count;
      logic [31:0]              pos0;
      logic                     found;
      logic [31:0]              offset;
      logic                     last;
   } job_type;

endpackage

### rtl/bsfr_front.sv
// ----------------------------------------------------------------------------
// bsfr_front
// accepts bytes, keeps the delay line and runs the signature compare
// ----------------------------------------------------------------------------
module bsfr_front #(
   parameter int MAX_SIGNATURE_BYTES = bsfr_pkg::MAX_SIGNATURE_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         signature,
   input  logic [3:0]          signature_length,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                queue_full,
   output logic                push,
   output bsfr_pkg::job_type   push_job
);
   import bsfr_pkg::*;

   localparam int LEN_CAP = (MAX_SIGNATURE_BYTES > PATCH_BYTES) ? PATCH_BYTES :
                            ((MAX_SIGNATURE_BYTES < 1) ? 1 : MAX_SIGNATURE_BYTES);

   logic [7:0]  hist_ff  [HISTORY_DEPTH];
   logic [7:0]  hist_in  [HISTORY_DEPTH];
   logic [2:0]  held_ff,  held_in;
   logic [31:0] index_ff, index_in;
   logic        seen_ff,  seen_in;
   logic [31:0] start_ff, start_in;

   logic [7:0]  win [PATCH_BYTES];
   logic [3:0]  len;
   logic [3:0]  held_p1;
   logic [3:0]  base;
   logic        window_ok;
   logic        eq;
   logic        hit;
   logic        seen_new;
   logic [31:0] start_new;
   logic        accept;
   logic        held_full;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign held_full = (held_ff == 3'(HISTORY_DEPTH));

   always_comb begin
      if (signature_length == 4'd0) begin
         len = 4'd1;
      end else if (signature_length > 4'(LEN_CAP)) begin
         len = 4'(LEN_CAP);
      end else begin
         len = signature_length;
      end
   end

   // held bytes oldest first, incoming byte right after them
   always_comb begin
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
         win[j] = (3'(j) < held_ff) ? hist_ff[j] : req_data_byte;
      end
      win[PATCH_BYTES-1] = req_data_byte;
   end

   assign held_p1   = {1'b0, held_ff} + 4'd1;
   assign window_ok = (held_p1 >= len);
   assign base      = held_p1 - len;

   // one compare lane per signature byte
   always_comb begin
      eq = 1'b1;
      for (int j = 0; j < LEN_CAP; j++) begin
         if (4'(j) < len) begin
            if (win[3'(base + 4'(j))] != signature[8*j +: 8]) begin
               eq = 1'b0;
            end
         end
      end
   end

   assign hit       = !seen_ff && window_ok && eq;
   assign seen_new  = seen_ff || hit;
   assign start_new = hit ? (index_ff - {28'd0, len - 4'd1}) : start_ff;

   always_comb begin
      for (int j = 0; j < PATCH_BYTES; j++) begin
         push_job.bytes[8*j +: 8] = win[j];
      end
      push_job.count  = req_last_byte ? held_p1 : 4'd1;
      push_job.pos0   = index_ff - {29'd0, held_ff};
      push_job.found  = seen_new;
      push_job.offset = seen_new ? start_new : 32'd0;
      push_job.last   = req_last_byte;
   end

   assign push = accept && (req_last_byte || held_full);

   always_comb begin
      hist_in  = hist_ff;
      held_in  = held_ff;
      index_in = index_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      if (accept) begin
         if (req_last_byte) begin
            held_in  = 3'd0;
            index_in = 32'd0;
            seen_in  = 1'b0;
            start_in = 32'd0;
         end else begin
            for (int j = 0; j < HISTORY_DEPTH; j++) begin
               if (held_full) begin
                  hist_in[j] = win[j+1];
               end else if (3'(j) == held_ff) begin
                  hist_in[j] = req_data_byte;
               end
            end
            held_in  = held_full ? held_ff : held_ff + 3'd1;
            index_in = (index_ff == '1) ? index_ff : index_ff + 32'd1;
            seen_in  = seen_new;
            start_in = start_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 3'd0;
         index_ff <= 32'd0;
         seen_ff  <= 1'b0;
         start_ff <= 32'd0;
      end else begin
         held_ff  <= held_in;
         index_ff <= index_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
      end
   end

endmodule

### rtl/bsfr_queue.sv
// ----------------------------------------------------------------------------
// bsfr_queue
// short fifo of jobs between the front and back end
// ----------------------------------------------------------------------------
module bsfr_queue #(
   parameter int DEPTH = bsfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsfr_pkg::job_type   push_job,
   input  logic                pop,
   output bsfr_pkg::job_type   head_job,
   output logic                empty,
   output logic                full
);
   import bsfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/bsfr_back.sv
// ----------------------------------------------------------------------------
// bsfr_back
// emits the bytes of each job one per cycle unless stalled, patching them where needed
// ----------------------------------------------------------------------------
module bsfr_back (
   input  logic                clock,
   input  logic                reset,
   input  bsfr_pkg::job_type   head_job,
   input  logic                empty,
   output logic                pop,
   input  logic                replace_enable,
   input  logic [63:0]         replacement_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last,
   output logic                rsp_found,
   output logic [31:0]         rsp_match_offset
);
   import bsfr_pkg::*;

   logic [2:0]  lane_ff,   lane_in;
   logic        valid_ff,  valid_in;
   logic [7:0]  byte_ff,   byte_in;
   logic        last_ff,   last_in;
   logic        found_ff,  found_in;
   logic [31:0] offset_ff, offset_in;

   logic [31:0] pos;
   logic [31:0] diff;
   logic        patch;
   logic        final_lane;
   logic        load;

   assign pos        = head_job.pos0 + {29'd0, lane_ff};
   assign diff       = pos - head_job.offset;
   assign patch      = replace_enable && head_job.found && (pos >= head_job.offset)
                       && (diff[31:3] == 29'd0);
   assign final_lane = (({1'b0, lane_ff} + 4'd1) == head_job.count);
   assign load       = !empty && (!valid_ff || rsp_ready);
   assign pop        = load && final_lane;

   always_comb begin
      lane_in   = lane_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      found_in  = found_ff;
      offset_in = offset_ff;
      if (load) begin
         valid_in  = 1'b1;
         byte_in   = patch ? replacement_value[{diff[2:0], 3'b000} +: 8]
                           : head_job.bytes[{lane_ff, 3'b000} +: 8];
         last_in   = head_job.last && final_lane;
         found_in  = head_job.found;
         offset_in = head_job.offset;
         lane_in   = final_lane ? 3'd0 : lane_ff + 3'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         lane_ff  <= lane_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_out_last     = last_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

### rtl/byte_signature_find_replace.sv
// ----------------------------------------------------------------------------
// byte_signature_find_replace
// streaming signature search with patch-over at the first match
// ----------------------------------------------------------------------------
// takes one byte word per cycle unless stalled and compares every window of
// signature_length bytes with the signature register; the first match start of
// the buffer is kept and, with replace_enable set, the eight bytes from there are
// replaced by replacement_value in little-endian order. bytes are held back in a
// seven-byte delay line, so results lag the input by seven words until a last
// word flushes the line. the front end takes one word a cycle unless the queue is
// full; a last word with n bytes in the delay line yields n+1 results which the
// back end emits one a cycle unless stalled, and a four-entry job queue lets the
// front end keep taking words while such a burst drains. sustained rate: one word
// a cycle when not stalled, set by the single-result-per-cycle output register
// ----------------------------------------------------------------------------
module byte_signature_find_replace #(
   parameter int MAX_SIGNATURE_BYTES = bsfr_pkg::MAX_SIGNATURE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH         = bsfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_out_last,
   output logic                              rsp_found,
   output logic [31:0]                       rsp_match_offset,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bsfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bsfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bsfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import bsfr_pkg::*;

   // configuration registers
   logic [63:0]   signature_ff,      signature_in;
   logic [3:0]    sig_length_ff,     sig_length_in;
   logic [63:0]   repl_value_ff,     repl_value_in;
   logic          repl_enable_ff,    repl_enable_in;

   logic          csr_write;
   csr_index_type csr_index;

   // front to queue to back
   logic          queue_full;
   logic          queue_empty;
   logic          push;
   logic          pop;
   job_type       push_job;
   job_type       head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   // registers sit eight bytes apart, low address bits ignored
   assign csr_index  = csr_index_type'(csr_paddr[4:3]);

   always_comb begin
      signature_in   = signature_ff;
      sig_length_in  = sig_length_ff;
      repl_value_in  = repl_value_ff;
      repl_enable_in = repl_enable_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SIGNATURE:   signature_in   = csr_pwdata;
            CSR_SIG_LENGTH:  sig_length_in  = csr_pwdata[3:0];
            CSR_REPL_VALUE:  repl_value_in  = csr_pwdata;
            CSR_REPL_ENABLE: repl_enable_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         CSR_SIGNATURE:   csr_prdata = signature_ff;
         CSR_SIG_LENGTH:  csr_prdata = {60'd0, sig_length_ff};
         CSR_REPL_VALUE:  csr_prdata = repl_value_ff;
         CSR_REPL_ENABLE: csr_prdata = {63'd0, repl_enable_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signature_ff   <= 64'd0;
         sig_length_ff  <= 4'd8;
         repl_value_ff  <= 64'd0;
         repl_enable_ff <= 1'b0;
      end else begin
         signature_ff   <= signature_in;
         sig_length_ff  <= sig_length_in;
         repl_value_ff  <= repl_value_in;
         repl_enable_ff <= repl_enable_in;
      end
   end

   // front end: delay line, window compare, first match tracking
   bsfr_front #(
      .MAX_SIGNATURE_BYTES (MAX_SIGNATURE_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .signature        (signature_ff),
      .signature_length (sig_length_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   // decoupling queue
   bsfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // back end: per-byte patch and output register
   bsfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .empty             (queue_empty),
      .pop               (pop),
      .replace_enable    (repl_enable_ff),
      .replacement_value (repl_value_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset)
   );

endmodule

### rtl/bsfr_checker.sv
// ----------------------------------------------------------------------------
// bsfr_checker
// port-level checks on the result channel of the find and replace block
// ----------------------------------------------------------------------------
module bsfr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_last,
   input  logic        rsp_found,
   input  logic [31:0] rsp_match_offset
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_found) && $stable(rsp_match_offset))
      else $error("stalled result word changed");

   // no offset without a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0)
      else $error("offset set without a match");

   // within a buffer a match stays found with the same start
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_found && !rsp_out_last |=>
         !rsp_valid || (rsp_found && rsp_match_offset == $past(rsp_match_offset)))
      else $error("first match lost or moved within a buffer");

   // nothing offered straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind byte_signature_find_replace bsfr_checker u_bsfr_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte signature find and replace block
// ----------------------------------------------------------------------------
// a queue of stream words feeds a valid/ready driver; every accepted word
// runs through a local model of the search, delay line and patch logic, and
// the bytes it should release are queued. a monitor compares each released
// word field by field with the oldest queued byte. registers are changed over
// the apb port only while the block is quiet. a short directed part is
// followed by random buffers under changing settings and stall patterns
// ----------------------------------------------------------------------------
module tb;
   import bsfr_pkg::*;

   // settle time after the last expected word, covers pipeline and job queue
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_WORDS  = 400;
   localparam int RUN_LIMIT     = 800000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_word_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        found;
      logic [31:0] offset;
   } due_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = '0;
   logic                  req_last_byte = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_out_last;
   logic                  rsp_found;
   logic [31:0]           rsp_match_offset;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // words waiting for the driver, bytes waiting for the monitor
   stream_word_type feed_words [$];
   due_word_type    due_bytes [$];

   int sender_idle_pct   = 27;
   int receiver_idle_pct = 64;
   int errors            = 0;
   int random_words      = 0;

   // register copies, reset values of the block
   logic [63:0] sig_reg  = '0;
   logic [3:0]  len_reg  = 4'd8;
   logic [63:0] repl_reg = '0;
   logic        repl_en  = 1'b0;

   // search state of the current buffer
   logic [7:0]  hist [HISTORY_DEPTH];
   int unsigned held        = 0;
   logic [31:0] byte_index  = '0;
   logic        match_seen  = 1'b0;
   logic [31:0] match_start = '0;

   byte_signature_find_replace DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // local model of the block
   // ------------------------------------------------------------------------

   // compare width after clamping: zero counts as one, the cap is eight lanes
   function automatic int unsigned active_len();
      int unsigned cap;
      cap = MAX_SIGNATURE_BYTES_DEFAULT;
      if (cap > PATCH_BYTES) cap = PATCH_BYTES;
      if (len_reg == 0) return 1;
      if (len_reg > cap) return cap;
      return len_reg;
   endfunction

   // one released byte, patched when it lies within eight bytes of the match
   task automatic emit_due(input logic [7:0] b, input logic [31:0] pos, input logic lst);
      longint unsigned p, s;
      due_word_type    w;
      p = pos;
      s = match_start;
      w.data = b;
      if (match_seen && repl_en && p >= s && p < s + PATCH_BYTES)
         w.data = repl_reg[8*int'(p - s) +: 8];
      w.last   = lst;
      w.found  = match_seen;
      w.offset = match_seen ? match_start : 32'd0;
      due_bytes.push_back(w);
   endtask

   task automatic advance_search(input logic [7:0] din, input logic lst);
      logic [7:0]  win [HISTORY_DEPTH+1];
      int unsigned h, len, base;
      logic [31:0] idx;
      bit          same;
      h   = held;
      idx = byte_index;
      len = active_len();
      for (int j = 0; j < h; j++) win[j] = hist[j];
      win[h] = din;
      // window ending on this byte, searched until the first hit
      if (!match_seen && h + 1 >= len) begin
         base = h + 1 - len;
         same = 1'b1;
         for (int j = 0; j < len; j++)
            if (win[base+j] != sig_reg[8*j +: 8]) same = 1'b0;
         if (same) begin
            match_seen  = 1'b1;
            match_start = idx - (len - 1);
         end
      end
      if (lst) begin
         // flush the whole delay line plus this byte
         for (int j = 0; j <= h; j++) emit_due(win[j], idx - h + j, j == h);
         held        = 0;
         byte_index  = '0;
         match_seen  = 1'b0;
         match_start = '0;
      end else begin
         if (h == HISTORY_DEPTH) begin
            emit_due(win[0], idx - h, 1'b0);
            for (int j = 0; j < HISTORY_DEPTH; j++) hist[j] = win[j+1];
         end else begin
            hist[h] = win[h];
            held    = h + 1;
         end
         if (byte_index != '1) byte_index++;
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: one word at a time from the feed queue
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_words
      stream_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) advance_search(req_data_byte, req_last_byte);
         // a held word stays put until taken
         if (!req_valid || req_ready) begin
            if (feed_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               w = feed_words.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= w.data;
               req_last_byte <= w.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: released words against the queued bytes
   // ------------------------------------------------------------------------
   task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
      $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin : watch_results
      due_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               $display("%0t unexpected word: expected none, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_out_last);
               errors++;
            end else begin
               want = due_bytes.pop_front();
               if (rsp_out_byte !== want.data) report("out_byte", want.data, rsp_out_byte);
               if (rsp_out_last !== want.last) report("out_last", want.last, rsp_out_last);
               if (rsp_found !== want.found) report("found", want.found, rsp_found);
               if (rsp_match_offset !== want.offset)
                  report("match_offset", want.offset, rsp_match_offset);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send(input logic [7:0] d, input logic lst);
      feed_words.push_back('{data: d, last: lst});
   endtask

   // nothing in flight, nothing owed, then let the pipeline settle;
   // checked again afterwards, a word taken from the feed on the same edge
   // may not show as valid yet
   task automatic wait_quiet();
      do begin
         while (feed_words.size() != 0 || req_valid || due_bytes.size() != 0)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (feed_words.size() != 0 || req_valid || due_bytes.size() != 0);
   endtask

   // apb write: setup then access, taken where pready is seen
   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(8 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_SIGNATURE:   sig_reg  = value;
         CSR_SIG_LENGTH:  len_reg  = value[3:0];
         CSR_REPL_VALUE:  repl_reg = value;
         CSR_REPL_ENABLE: repl_en  = value[0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] pick_wide();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 2) return '0;
      if (r == 2) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic pick_settings();
      logic [63:0] len_value;
      // out-of-range lengths now and then, zero and above eight included
      len_value = 64'(($urandom_range(3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 8));
      write_reg(CSR_SIGNATURE, pick_wide());
      write_reg(CSR_SIG_LENGTH, len_value);
      write_reg(CSR_REPL_VALUE, pick_wide());
      write_reg(CSR_REPL_ENABLE, 64'($urandom_range(1)));
   endtask

   // random buffer, mostly short, usually with the signature planted in it
   task automatic queue_random_buffer();
      logic [7:0]  content [40];
      int unsigned count, len, at, mode;
      count = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      len   = active_len();
      mode  = $urandom_range(2);
      for (int k = 0; k < count; k++) begin
         case (mode)
            // signature lanes mixed with noise give partial and repeated hits
            1: content[k] = ($urandom_range(4) != 0) ?
                            sig_reg[8*$urandom_range(0, len - 1) +: 8] : 8'($urandom);
            2: content[k] = ($urandom_range(1) != 0) ? 8'h00 : 8'hff;
            default: content[k] = 8'($urandom);
         endcase
      end
      if ($urandom_range(99) < 70 && count >= len) begin
         at = $urandom_range(0, count - len);
         for (int k = 0; k < len; k++) content[at+k] = sig_reg[8*k +: 8];
      end
      for (int k = 0; k < count; k++) send(content[k], k == count - 1);
      random_words += count;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single-byte buffer under reset settings, no window fits
      send(8'h00, 1'b1);
      wait_quiet();

      // zero length acts as one lane, upper signature bytes ignored,
      // patch runs past the buffer end and is cut short
      write_reg(CSR_SIGNATURE, 64'hffff_ffff_ffff_ffab);
      write_reg(CSR_SIG_LENGTH, 64'd0);
      write_reg(CSR_REPL_VALUE, '1);
      write_reg(CSR_REPL_ENABLE, 64'd1);
      send(8'h00, 1'b0);
      send(8'hff, 1'b0);
      send(8'hab, 1'b0);
      send(8'h12, 1'b1);
      wait_quiet();

      // length above the cap clamps to eight, delay line fills and spills
      write_reg(CSR_SIGNATURE, '1);
      write_reg(CSR_SIG_LENGTH, 64'd15);
      write_reg(CSR_REPL_VALUE, '0);
      for (int k = 0; k < 9; k++) send(8'hff, k == 8);
      wait_quiet();

      // match while patching is off, then switched on with bytes still held
      write_reg(CSR_SIGNATURE, 64'h3c5a);
      write_reg(CSR_SIG_LENGTH, 64'd2);
      write_reg(CSR_REPL_VALUE, 64'h1122_3344_5566_7788);
      write_reg(CSR_REPL_ENABLE, 64'd0);
      send(8'h5a, 1'b0);
      send(8'h3c, 1'b0);
      send(8'h00, 1'b0);
      wait_quiet();
      write_reg(CSR_REPL_ENABLE, 64'd1);
      send(8'h7e, 1'b0);
      send(8'h80, 1'b1);
      wait_quiet();

      // all-zero signature, only the first of several hits counts
      write_reg(CSR_SIGNATURE, '0);
      write_reg(CSR_SIG_LENGTH, 64'd1);
      write_reg(CSR_REPL_VALUE, 64'h0123_4567_89ab_cdef);
      send(8'h01, 1'b0);
      send(8'h00, 1'b0);
      send(8'h00, 1'b1);
      wait_quiet();

      // random buffers in batches, new settings between batches
      while (random_words < RANDOM_WORDS) begin
         if (random_words < RANDOM_WORDS / 3) begin
            sender_idle_pct   = 27;
            receiver_idle_pct = 64;
         end else if (random_words < 2 * RANDOM_WORDS / 3) begin
            sender_idle_pct   = 64;
            receiver_idle_pct = 27;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         pick_settings();
         repeat ($urandom_range(2, 6)) queue_random_buffer();
         wait_quiet();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
